>>> rtl/dnpc_pkg.sv
// Package for the day/night palette crossfade block.
// Holds theme and command codes, the palette tables and the sequencer state type.
// No dependencies.
`default_nettype none

package dnpc_pkg;

  // Theme codes
  localparam logic [1:0] THM_DAWN  = 2'd0;
  localparam logic [1:0] THM_DAY   = 2'd1;
  localparam logic [1:0] THM_DUSK  = 2'd2;
  localparam logic [1:0] THM_NIGHT = 2'd3;

  // Event kinds
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_TIME    = 2'd1;
  localparam logic [1:0] CMD_FORCE   = 2'd2;
  localparam logic [1:0] CMD_AMBIENT = 2'd3;

  // Configuration register indexes
  localparam logic REG_AUTO_BRIGHTNESS = 1'b0;
  localparam logic REG_FADE_LENGTH     = 1'b1;

  // Reset values and limits
  localparam logic [15:0] RST_FADE_LENGTH = 16'd5000;
  localparam logic [6:0]  RST_AMBIENT     = 7'd50;
  localparam logic [7:0]  AMBIENT_MAX     = 8'd100;

  // Day boundaries in minutes
  localparam logic [10:0] MIN_DAWN  = 11'd300;
  localparam logic [10:0] MIN_DAY   = 11'd420;
  localparam logic [10:0] MIN_DUSK  = 11'd1080;
  localparam logic [10:0] MIN_NIGHT = 11'd1200;

  // Serial step counts: one bit of the weights per multiply step,
  // one quotient bit per divide step (quotient never exceeds 8 bits)
  localparam int MUL_STEPS = 16;
  localparam int DIV_STEPS = 8;
  localparam int LANES     = 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  function automatic logic [1:0] minutes_to_theme(input logic [10:0] m);
    logic [1:0] t;
    if (m >= MIN_DAWN && m < MIN_DAY)        t = THM_DAWN;
    else if (m >= MIN_DAY && m < MIN_DUSK)   t = THM_DAY;
    else if (m >= MIN_DUSK && m < MIN_NIGHT) t = THM_DUSK;
    else                                     t = THM_NIGHT;
    return t;
  endfunction

  function automatic logic [23:0] palette_bg(input logic [1:0] t);
    logic [23:0] c;
    case (t)
      THM_DAWN:  c = 24'hFFE4C4;
      THM_DAY:   c = 24'h87CEEB;
      THM_DUSK:  c = 24'h4A2C6E;
      THM_NIGHT: c = 24'h0D1B2A;
      default:   c = 24'h87CEEB;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] palette_bri(input logic [1:0] t);
    logic [6:0] b;
    case (t)
      THM_DAWN:  b = 7'd70;
      THM_DAY:   b = 7'd100;
      THM_DUSK:  b = 7'd60;
      THM_NIGHT: b = 7'd40;
      default:   b = 7'd100;
    endcase
    return b;
  endfunction

  // Lane 0 red, 1 green, 2 blue, 3 brightness
  function automatic logic [7:0] lane_value(input logic [1:0] t, input logic [1:0] lane);
    logic [23:0] c;
    logic [7:0]  v;
    c = palette_bg(t);
    case (lane)
      2'd0:    v = c[23:16];
      2'd1:    v = c[15:8];
      2'd2:    v = c[7:0];
      default: v = {1'b0, palette_bri(t)};
    endcase
    return v;
  endfunction

  function automatic logic [6:0] ambient_to_bri(input logic [6:0] lvl);
    logic [6:0] b;
    if (lvl < 7'd10)      b = 7'd20;
    else if (lvl < 7'd30) b = 7'd40;
    else if (lvl < 7'd50) b = 7'd60;
    else if (lvl < 7'd70) b = 7'd80;
    else                  b = 7'd100;
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/day_night_palette_crossfade.sv
// A result appears on m_tvalid once its event is transferred and the sequencer has run
// load, 16 multiply steps, 8 divide steps and finish; a low m_tready holds it in finish.
// The block accepts no new event until the sequencer is back in idle, so events
// go one at a time through the bit-serial multiply and divide.
// Reset (rst, synchronous): shown and goal theme day, no fade, ambient 50,
// auto brightness on, fade length 5000 ticks, output empty.
// Depends on dnpc_pkg.
`default_nettype none

module day_night_palette_crossfade (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  // Event stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // minutes[10:0], theme_request[13:11], light_level[21:14]
  input  wire logic [1:0]  s_tuser,   // cmd
  // Result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // bg_rgb[23:0], brightness[30:24], shown_theme[32:31],
                                      // goal_theme[34:33], fading[35], theme_changed[36],
                                      // prior_theme[38:37]
);
  import dnpc_pkg::*;

  // Configuration
  logic        auto_bri;
  logic [15:0] fade_len;

  // Theme state
  logic [1:0]  current_theme, current_theme_next;
  logic [1:0]  target_theme, target_theme_next;
  logic [15:0] elapsed, elapsed_next;
  logic        in_fade, in_fade_next;
  logic [6:0]  ambient, ambient_next;
  logic        changed, changed_next;
  logic [1:0]  prior;

  // Sequencer
  seq_state_t  state, state_next;
  logic [3:0]  cnt;
  logic        s_xfer;

  // Serial datapath
  logic [15:0] d_eff;
  logic [15:0] e_eff;
  logic [15:0] de_sh;
  logic [15:0] e_sh;
  logic [23:0] dsh;
  logic [23:0] acc [LANES];
  logic [7:0]  quo [LANES];
  logic [7:0]  a_val [LANES];
  logic [7:0]  b_val [LANES];

  // Event fields
  logic [1:0]  cmd;
  logic [10:0] minutes;
  logic [2:0]  theme_req;
  logic [7:0]  light_level;

  // Result assembly
  logic        interp;
  logic [23:0] bg_out;
  logic [6:0]  bri_out;

  assign cmd         = s_tuser;
  assign minutes     = s_tdata[10:0];
  assign theme_req   = s_tdata[13:11];
  assign light_level = s_tdata[21:14];

  assign s_tready = (state == ST_IDLE);
  assign s_xfer   = s_tvalid && s_tready;

  // A zero fade length counts as one tick; elapsed is clamped to the length
  assign d_eff = (fade_len == 16'd0) ? 16'd1 : fade_len;
  assign e_eff = (elapsed > d_eff) ? d_eff : elapsed;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      auto_bri <= 1'b1;
      fade_len <= RST_FADE_LENGTH;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_AUTO_BRIGHTNESS: auto_bri <= cfg_data[0];
        REG_FADE_LENGTH:     fade_len <= cfg_data;
        default:             ;
      endcase
    end
  end

  // Apply one event to the theme state in the transfer cycle
  always_comb begin
    logic [15:0] el_inc;
    logic        want_ok;
    logic [1:0]  want;
    current_theme_next = current_theme;
    target_theme_next  = target_theme;
    elapsed_next       = elapsed;
    in_fade_next       = in_fade;
    ambient_next       = ambient;
    changed_next       = 1'b0;
    want_ok            = 1'b0;
    want               = minutes_to_theme(minutes);
    el_inc             = (elapsed != 16'hFFFF) ? elapsed + 16'd1 : elapsed;
    case (cmd)
      CMD_TICK: begin
        // advance the fade; hand over the theme once the length is reached
        if (in_fade) begin
          elapsed_next = el_inc;
          if (el_inc >= d_eff) begin
            in_fade_next       = 1'b0;
            current_theme_next = target_theme;
          end
        end
      end
      CMD_TIME: begin
        want_ok = 1'b1;
      end
      CMD_FORCE: begin
        // requests beyond night are dropped
        want_ok = !theme_req[2];
        want    = theme_req[1:0];
      end
      CMD_AMBIENT: begin
        ambient_next = (light_level > AMBIENT_MAX) ? AMBIENT_MAX[6:0] : light_level[6:0];
      end
      default: ;
    endcase
    // a new goal restarts the fade, even when it matches the shown theme
    if (want_ok && want != target_theme) begin
      target_theme_next = want;
      elapsed_next      = 16'd0;
      in_fade_next      = 1'b1;
      changed_next      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_theme <= THM_DAY;
      target_theme  <= THM_DAY;
      elapsed       <= 16'd0;
      in_fade       <= 1'b0;
      ambient       <= RST_AMBIENT;
    end else if (s_xfer) begin
      current_theme <= current_theme_next;
      target_theme  <= target_theme_next;
      elapsed       <= elapsed_next;
      in_fade       <= in_fade_next;
      ambient       <= ambient_next;
    end
  end

  // Per-item flags held for the result
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      changed <= changed_next;
      prior   <= target_theme;
    end
  end

  // Sequencer: load, multiply, divide, then wait for the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_xfer) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_MUL;
      ST_MUL:  if (cnt == 4'(MUL_STEPS - 1)) state_next = ST_DIV;
      ST_DIV:  if (cnt == 4'(DIV_STEPS - 1)) state_next = ST_DONE;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 4'd0;
    end else if ((state == ST_MUL && cnt == 4'(MUL_STEPS - 1)) ||
                 (state == ST_DIV && cnt == 4'(DIV_STEPS - 1)) ||
                 state == ST_LOAD) begin
      cnt <= 4'd0;
    end else if (state == ST_MUL || state == ST_DIV) begin
      cnt <= cnt + 4'd1;
    end
  end

  // Lane endpoints: a from the shown palette, b from the goal palette
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      a_val[i] = lane_value(current_theme, 2'(i));
      b_val[i] = lane_value(target_theme, 2'(i));
    end
  end

  // Numerator a*(D-e) + b*e built MSB first from the weight bits, then
  // divided by D one quotient bit per step. The quotient fits 8 bits since
  // the numerator never exceeds max(a,b)*D.
  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        de_sh <= d_eff - e_eff;
        e_sh  <= e_eff;
        dsh   <= {1'b0, d_eff, 7'd0};
        for (int i = 0; i < LANES; i++) begin
          acc[i] <= 24'd0;
        end
      end
      ST_MUL: begin
        de_sh <= {de_sh[14:0], 1'b0};
        e_sh  <= {e_sh[14:0], 1'b0};
        for (int i = 0; i < LANES; i++) begin
          acc[i] <= {acc[i][22:0], 1'b0}
                  + (de_sh[15] ? {16'd0, a_val[i]} : 24'd0)
                  + (e_sh[15]  ? {16'd0, b_val[i]} : 24'd0);
        end
      end
      ST_DIV: begin
        dsh <= {1'b0, dsh[23:1]};
        for (int i = 0; i < LANES; i++) begin
          if (acc[i] >= dsh) begin
            acc[i] <= acc[i] - dsh;
            quo[i] <= {quo[i][6:0], 1'b1};
          end else begin
            quo[i] <= {quo[i][6:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // Result: blend only while fading between two different themes
  assign interp  = in_fade && (current_theme != target_theme);
  assign bg_out  = interp ? {quo[0], quo[1], quo[2]} : palette_bg(current_theme);
  assign bri_out = auto_bri ? ambient_to_bri(ambient)
                 : (interp ? quo[3][6:0] : palette_bri(current_theme));

  // Output register: hold the result until its transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= {1'b0, prior, changed, in_fade, target_theme, current_theme,
                  bri_out, bg_out};
    end
  end

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for the day/night palette crossfade block.
// Streams events in bursts, predicts every result in-bench and checks it field by field.
// Depends on dnpc_pkg and day_night_palette_crossfade.
`timescale 1ns / 1ps

module tb;
  import dnpc_pkg::*;

  // Run limits
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_EVENTS = 160;  // random events per register setting
  localparam int HOLD_AFTER   = 700;  // results seen before the long output hold
  localparam int HOLD_CYCLES  = 600;  // length of that hold
  localparam int SETTLE       = 40;   // margin after the last result

  // One input event, fields as the block sees them
  typedef struct {
    logic [1:0]  cmd;
    logic [10:0] minutes;
    logic [2:0]  req;
    logic [7:0]  light;
  } event_t;

  // One display look, as carried by a result transfer
  typedef struct {
    logic [23:0] bg;
    logic [6:0]  bri;
    logic [1:0]  shown;
    logic [1:0]  goal;
    logic        fading;
    logic        changed;
    logic [1:0]  prior;
  } look_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = REG_AUTO_BRIGHTNESS;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = '0;
  logic [1:0]  s_tuser   = CMD_TICK;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;

  day_night_palette_crossfade u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // minutes[10:0], theme_request[13:11], light_level[21:14]
    .s_tuser   (s_tuser),   // cmd
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)    // bg_rgb[23:0], brightness[30:24], shown_theme[32:31],
                            // goal_theme[34:33], fading[35], theme_changed[36],
                            // prior_theme[38:37]
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Theme model: the bench's own copy of the block state and registers
  // ---------------------------------------------------------------------------
  logic        mdl_auto     = 1'b1;
  logic [15:0] mdl_fade_len = RST_FADE_LENGTH;
  logic [1:0]  mdl_shown    = THM_DAY;
  logic [1:0]  mdl_goal     = THM_DAY;
  logic [15:0] mdl_elapsed  = '0;
  logic        mdl_fading   = 1'b0;
  logic [6:0]  mdl_ambient  = RST_AMBIENT;

  event_t event_q[$];    // events waiting for the driver
  look_t  looks_due[$];  // predicted looks, oldest first

  int pushed_cnt    = 0;
  int accepted_cnt  = 0;
  int results_seen  = 0;
  int mismatch_cnt  = 0;
  int goal_changes  = 0;
  int fades_done    = 0;
  int settings_used = 1;
  int cycle_cnt     = 0;

  // Palette entry per theme: brightness in the top bits, background below
  function automatic logic [30:0] palette_of(input logic [1:0] t);
    logic [30:0] p;
    case (t)
      THM_DAWN:  p = {7'd70,  24'hFFE4C4};
      THM_DAY:   p = {7'd100, 24'h87CEEB};
      THM_DUSK:  p = {7'd60,  24'h4A2C6E};
      default:   p = {7'd40,  24'h0D1B2A};
    endcase
    return p;
  endfunction

  // floor((a*D + (b-a)*e) / D); never negative because e <= D
  function automatic int blend(input int a, input int b, input int e, input int d);
    return (a * d + (b - a) * e) / d;
  endfunction

  // Apply one event to the model and return the look the block must report
  function automatic look_t apply_event(input event_t ev);
    look_t       r;
    int          d;
    int          e;
    logic [2:0]  want;
    logic [30:0] pa;
    logic [30:0] pb;
    d = (mdl_fade_len == 0) ? 1 : int'(mdl_fade_len);  // zero length acts as one tick
    r.prior   = mdl_goal;
    r.changed = 1'b0;
    want      = 3'd4;  // no theme wanted
    case (ev.cmd)
      CMD_TICK: begin
        // Tick while idle changes nothing
        if (mdl_fading) begin
          if (mdl_elapsed != 16'hFFFF) mdl_elapsed++;
          if (int'(mdl_elapsed) >= d) begin
            mdl_fading = 1'b0;
            mdl_shown  = mdl_goal;
            fades_done++;
          end
        end
      end
      CMD_TIME: begin
        if (ev.minutes >= MIN_DAWN && ev.minutes < MIN_DAY)        want = {1'b0, THM_DAWN};
        else if (ev.minutes >= MIN_DAY && ev.minutes < MIN_DUSK)   want = {1'b0, THM_DAY};
        else if (ev.minutes >= MIN_DUSK && ev.minutes < MIN_NIGHT) want = {1'b0, THM_DUSK};
        else                                                       want = {1'b0, THM_NIGHT};
      end
      CMD_FORCE: want = ev.req;  // 4..7 fall through as no request
      default: mdl_ambient = (ev.light > AMBIENT_MAX) ? AMBIENT_MAX[6:0] : ev.light[6:0];
    endcase

    // A new goal restarts the fade, even when it equals the shown theme
    if (want < 3'd4 && want[1:0] != mdl_goal) begin
      mdl_goal    = want[1:0];
      mdl_elapsed = '0;
      mdl_fading  = 1'b1;
      r.changed   = 1'b1;
      goal_changes++;
    end

    pa = palette_of(mdl_shown);
    pb = palette_of(mdl_goal);
    if (mdl_fading && mdl_shown != mdl_goal) begin
      // Clamp e so a shortened fade shows the goal palette until the next tick
      e = (int'(mdl_elapsed) > d) ? d : int'(mdl_elapsed);
      r.bg[23:16] = 8'(blend(pa[23:16], pb[23:16], e, d));
      r.bg[15:8]  = 8'(blend(pa[15:8],  pb[15:8],  e, d));
      r.bg[7:0]   = 8'(blend(pa[7:0],   pb[7:0],   e, d));
      r.bri       = 7'(blend(pa[30:24], pb[30:24], e, d));
    end else begin
      r.bg  = pa[23:0];
      r.bri = pa[30:24];
    end
    if (mdl_auto) begin
      if (mdl_ambient < 7'd10)      r.bri = 7'd20;
      else if (mdl_ambient < 7'd30) r.bri = 7'd40;
      else if (mdl_ambient < 7'd50) r.bri = 7'd60;
      else if (mdl_ambient < 7'd70) r.bri = 7'd80;
      else                          r.bri = 7'd100;
    end
    r.shown  = mdl_shown;
    r.goal   = mdl_goal;
    r.fading = mdl_fading;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Event driver: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  event_t      on_bus;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      // Predict at the transfer, so the model sees events in bus order
      if (s_tvalid && s_tready) begin
        looks_due.push_back(apply_event(on_bus));
        accepted_cnt++;
      end
      // Hold an offered event until it transfers, then pick the next one
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (event_q.size() != 0) begin
          on_bus = event_q.pop_front();
          s_tdata  <= {2'b00, on_bus.light, on_bus.req, on_bus.minutes};
          s_tuser  <= on_bus.cmd;
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            // Zero gaps now and then give back-to-back stretches
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
          end else begin
            burst_left--;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: own stall pattern plus one long hold to back the block up
  // ---------------------------------------------------------------------------
  int unsigned rdy_left    = 0;
  int unsigned hold_left   = 0;
  bit          ready_phase = 1'b0;
  bit          hold_done   = 1'b0;

  always @(posedge clk) begin
    if (!rst) begin
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        if (rdy_left == 0) begin
          ready_phase = !ready_phase;
          if (ready_phase)
            rdy_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 40);
          else
            rdy_left = $urandom_range(1, 25);
        end
        rdy_left--;
        m_tready <= ready_phase;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest predicted look
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [23:0] want,
                             input logic [23:0] got);
    if (want !== got) begin
      mismatch_cnt++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin : result_mon
    look_t got;
    look_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.bg      = m_tdata[23:0];
      got.bri     = m_tdata[30:24];
      got.shown   = m_tdata[32:31];
      got.goal    = m_tdata[34:33];
      got.fading  = m_tdata[35];
      got.changed = m_tdata[36];
      got.prior   = m_tdata[38:37];
      results_seen++;
      if (looks_due.size() == 0) begin
        mismatch_cnt++;
        $display("%0t ns: result with none expected, expected nothing, actual %0h",
                 $time, m_tdata);
      end else begin
        want = looks_due.pop_front();
        check_field("bg_rgb",        want.bg,      got.bg);
        check_field("brightness",    want.bri,     got.bri);
        check_field("shown_theme",   want.shown,   got.shown);
        check_field("goal_theme",    want.goal,    got.goal);
        check_field("fading",        want.fading,  got.fading);
        check_field("theme_changed", want.changed, got.changed);
        check_field("prior_theme",   want.prior,   got.prior);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d looks outstanding",
               cycle_cnt, looks_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Every field random, so unused fields toggle too
  function automatic event_t any_event();
    event_t ev;
    ev.cmd     = 2'($urandom_range(0, 3));
    ev.minutes = 11'($urandom_range(0, 2047));
    ev.req     = 3'($urandom_range(0, 7));
    ev.light   = 8'($urandom_range(0, 255));
    return ev;
  endfunction

  task automatic push_event(input event_t ev);
    event_q.push_back(ev);
    pushed_cnt++;
  endtask

  // Directed event: set the field that the command reads, leave the rest random
  task automatic push_cmd(input logic [1:0] cmd, input int val);
    event_t ev;
    ev     = any_event();
    ev.cmd = cmd;
    case (cmd)
      CMD_TIME:    ev.minutes = 11'(val);
      CMD_FORCE:   ev.req     = 3'(val);
      CMD_AMBIENT: ev.light   = 8'(val);
      default:     ;
    endcase
    push_event(ev);
  endtask

  // Block until every queued event has transferred and every look has come back
  task automatic wait_drained();
    while (accepted_cnt != pushed_cnt || looks_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Register write; only called while the block is drained
  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_AUTO_BRIGHTNESS) mdl_auto = val[0];
    else                            mdl_fade_len = val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Random phase: mostly a goal change followed by a run of ticks long enough
  // to finish short fades, with ambient readings mixed in; the rest is noise
  task automatic random_phase(input bit auto_on, input logic [15:0] fade);
    event_t ev;
    int     n;
    int     span;
    int     base;
    wait_drained();
    write_reg(REG_AUTO_BRIGHTNESS, {15'd0, auto_on});
    write_reg(REG_FADE_LENGTH, fade);
    settings_used++;
    span = (mdl_fade_len > 16'd28) ? 30 : int'(mdl_fade_len) + 2;
    n = 0;
    while (n < PHASE_EVENTS) begin
      ev = any_event();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 1) == 1) begin
          ev.cmd = CMD_TIME;
          if ($urandom_range(0, 1) == 1) begin
            // Land on or next to a day boundary
            case ($urandom_range(0, 3))
              0:       base = MIN_DAWN;
              1:       base = MIN_DAY;
              2:       base = MIN_DUSK;
              default: base = MIN_NIGHT;
            endcase
            ev.minutes = 11'(base - 1 + int'($urandom_range(0, 2)));
          end
        end else begin
          ev.cmd = CMD_FORCE;
          if ($urandom_range(0, 3) != 0) ev.req = 3'($urandom_range(0, 3));
        end
        push_event(ev);
        n++;
        repeat ($urandom_range(0, span)) begin
          ev     = any_event();
          ev.cmd = ($urandom_range(0, 5) == 0) ? CMD_AMBIENT : CMD_TICK;
          push_event(ev);
          n++;
        end
      end else begin
        push_event(ev);
        n++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: auto brightness, 5000-tick fade
    push_cmd(CMD_TICK, 0);          // tick with no fade running
    push_cmd(CMD_AMBIENT, 0);
    push_cmd(CMD_AMBIENT, 9);
    push_cmd(CMD_AMBIENT, 10);
    push_cmd(CMD_AMBIENT, 69);
    push_cmd(CMD_AMBIENT, 255);     // clamps to full scale
    push_cmd(CMD_AMBIENT, 101);
    push_cmd(CMD_TIME, 419);        // last dawn minute starts a fade
    push_cmd(CMD_FORCE, THM_DAWN);  // same goal, nothing happens
    push_cmd(CMD_FORCE, 7);         // out-of-range requests are dropped
    push_cmd(CMD_FORCE, 4);
    push_cmd(CMD_TIME, 420);        // goal back to the shown theme
    push_cmd(CMD_TICK, 0);
    push_cmd(CMD_TIME, 1439);
    push_cmd(CMD_TIME, 0);
    push_cmd(CMD_TIME, 2047);       // beyond a day still reads as night
    push_cmd(CMD_TIME, 300);
    push_cmd(CMD_TIME, 299);
    push_cmd(CMD_TIME, 1080);
    push_cmd(CMD_TIME, 1199);
    push_cmd(CMD_TIME, 1200);
    push_cmd(CMD_TIME, 1079);

    // Longest fade with palette brightness, then shorten it mid-fade
    wait_drained();
    write_reg(REG_AUTO_BRIGHTNESS, 16'd0);
    write_reg(REG_FADE_LENGTH, 16'hFFFF);
    settings_used++;
    push_cmd(CMD_FORCE, THM_NIGHT);
    repeat (4) push_cmd(CMD_TICK, 0);
    wait_drained();
    write_reg(REG_FADE_LENGTH, 16'd2);
    settings_used++;
    push_cmd(CMD_AMBIENT, 30);      // elapsed past the new length: goal palette
    push_cmd(CMD_TICK, 0);          // and the next tick ends the fade

    // Zero fade length behaves as a single tick
    wait_drained();
    write_reg(REG_FADE_LENGTH, 16'd0);
    settings_used++;
    push_cmd(CMD_FORCE, THM_DAWN);
    push_cmd(CMD_AMBIENT, 5);
    push_cmd(CMD_TICK, 0);
    push_cmd(CMD_TICK, 0);

    random_phase(1'b0, 16'd1);
    random_phase(1'b1, 16'd3);
    random_phase(1'b0, 16'd8);
    random_phase(1'b0, 16'd2);
    random_phase(1'b1, 16'd20);
    random_phase(1'b0, 16'd5);
    random_phase(1'b0, 16'hFFFF);
    random_phase(1'b1, 16'd0);
    random_phase(1'b0, 16'd13);
    random_phase(1'b1, 16'd4);

    wait_drained();
    repeat (SETTLE) @(posedge clk);

    $display("Ran %0d events under %0d register settings, %0d results checked",
             accepted_cnt, settings_used, results_seen);
    $display("Goal theme changed %0d times, %0d crossfades ran to completion",
             goal_changes, fades_done);
    if (mismatch_cnt == 0) $display("SUCCESS");
    else                   $display("FAILURE");
    $finish;
  end

endmodule

>>> filelist.f
rtl/dnpc_pkg.sv
rtl/day_night_palette_crossfade.sv
verif/tb.sv
